// ===== hw/rtl/sequence_reorder_window_top_macros.svh =====
// Assertion macros shared by the reorder window checker.
`ifndef SEQUENCE_REORDER_WINDOW_TOP_MACROS_SVH
`define SEQUENCE_REORDER_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SRW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SRW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srw_pkg.sv =====
// Types and constants for the sequence reorder window.
package srw_pkg;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 13;
  localparam int SLOT_W = 5;
  localparam int CFG_W  = 6;
  localparam logic [CFG_W-1:0] CFG_WINDOW_RESET = 6'd32;

  typedef enum logic [1:0] {
    KIND_STORED = 2'd0,
    KIND_LATE   = 2'd1,
    KIND_DUP    = 2'd2,
    KIND_EMIT   = 2'd3
  } srw_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_MOD_S,
    ST_MOD_B,
    ST_DISP,
    ST_F_CHK,
    ST_F_EMIT,
    ST_STORE,
    ST_MOD_BOT,
    ST_I_CHK,
    ST_I_EMIT,
    ST_FINISH
  } srw_state_t;

  typedef struct packed {
    srw_kind_t          kind;
    logic [SEQ_W-1:0]   seq;
    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   len;
    logic               restarted;
  } srw_result_t;

  typedef struct packed {
    logic clear_all;
    logic free_slot;
    logic store;
    logic store_good;
  } srw_slot_cmd_t;

endpackage

// ===== hw/rtl/sequence_reorder_window_top.sv =====
// Sequence reorder window: one packet per transfer, disposition then in-order emits.
// Disposition is held back until the next result is known, so a forced walk delays it; the block
// takes no new packet until the last result of the current one has moved to the output register;
// forced walks, in-order releases, freed slots and output stalls all lengthen the time per packet.
// Reset (rst_n low, synchronous): empty window at zero, all slots cleared, window length 32.
module sequence_reorder_window_top import srw_pkg::*; #(
  parameter int MAX_WINDOW       = 32,
  parameter int RESTART_DISTANCE = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_window_length,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic              in_crc_ok,
  input  logic [LEN_W-1:0]  in_payload_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [LEN_W-1:0]  out_length,
  output logic              out_restarted,
  output logic              out_last
);

  localparam int RW    = $clog2(MAX_WINDOW + 1);
  localparam int IW    = $clog2(MAX_WINDOW);
  localparam int CNT_W = RW + 1;

  srw_state_t       state_r, state_nxt;
  logic [CFG_W-1:0] wl_r;
  logic [RW-1:0]    w_eff;
  logic [RW-1:0]    w_r;
  logic [SEQ_W-1:0] s_r;
  logic             ok_r;
  logic [LEN_W-1:0] plen_r;
  logic             restart_r;
  logic [SEQ_W-1:0] bottom_r;
  logic [SEQ_W-1:0] top_r;
  logic [SEQ_W-1:0] d_r;
  logic             ge_r;
  logic [SEQ_W-1:0] nbt_r;
  logic             forced_r;
  logic [RW-1:0]    k_r;
  logic             late_r;
  logic [IW-1:0]    didx_r;
  srw_kind_t        kind_r;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    idx_inc;
  logic [SEQ_W-1:0] pos_r;
  logic [CNT_W-1:0] cnt_r;
  srw_result_t      pend_r;
  logic             pend_v_r;
  srw_result_t      out_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic             in_acc;
  logic             restart_c;
  logic [SEQ_W-1:0] top_nxt;
  logic             push_ok;
  logic             fin_ok;
  logic             push;
  logic             fin;
  logic             adv;
  srw_result_t      push_res;
  srw_result_t      disp_res;
  srw_kind_t        disp_kind;
  logic [RW:0]      rel;
  logic             visited;
  logic             walk_end;
  logic             io_stop;
  logic             bottom_max;
  logic             mod_start;
  logic [SEQ_W-1:0] mod_div;
  logic             mod_done;
  logic [RW-1:0]    mod_rem;
  srw_slot_cmd_t    slot_cmd;
  logic             walk_valid;
  logic             walk_good;
  logic             store_good;
  logic [LEN_W-1:0] walk_len;

  srw_mod #(.RW(RW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_div),
    .divisor  (w_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  srw_slots #(.NSLOT(MAX_WINDOW), .IW(IW)) u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (slot_cmd),
    .walk_idx   (idx_r),
    .store_idx  (didx_r),
    .store_len  (plen_r),
    .walk_valid (walk_valid),
    .walk_good  (walk_good),
    .store_good (store_good),
    .walk_len   (walk_len)
  );

  // out-of-range window settings clamp to 1 .. MAX_WINDOW
  always_comb begin
    if (wl_r == '0) begin
      w_eff = RW'(1);
    end else if (wl_r > CFG_W'(MAX_WINDOW)) begin
      w_eff = RW'(MAX_WINDOW);
    end else begin
      w_eff = RW'(wl_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign restart_c = in_crc_ok &&
      (({1'b0, in_seq_number} + (SEQ_W + 1)'(RESTART_DISTANCE)) < {1'b0, bottom_r});

  always_comb begin
    if (restart_c || (in_seq_number > top_r)) begin
      top_nxt = in_seq_number;
    end else begin
      top_nxt = top_r;
    end
  end

  // one pending result is held back until it is known whether it is the last
  assign push_ok = !pend_v_r || !out_valid_r || out_ready;
  assign fin_ok  = !out_valid_r || out_ready;

  assign idx_inc    = ((RW'(idx_r) + RW'(1)) == w_r) ? '0 : idx_r + IW'(1);
  assign walk_end   = ({1'b0, k_r} == CNT_W'(cnt_r));
  assign io_stop    = (cnt_r > CNT_W'(w_r)) || (bottom_r > top_r) || !walk_good;
  assign bottom_max = (bottom_r == '1);

  // is the new packet's slot among those the forced walk frees
  always_comb begin
    if (didx_r >= idx_r) begin
      rel = (RW + 1)'(didx_r) - (RW + 1)'(idx_r);
    end else begin
      rel = (RW + 1)'(didx_r) + (RW + 1)'(w_r) - (RW + 1)'(idx_r);
    end
    visited = forced_r && ((k_r == w_r) || (rel < (RW + 1)'(k_r)));
    if (late_r) begin
      disp_kind = KIND_LATE;
    end else if (store_good && !visited) begin
      disp_kind = KIND_DUP;
    end else begin
      disp_kind = KIND_STORED;
    end
    disp_res.kind      = disp_kind;
    disp_res.seq       = s_r;
    disp_res.slot      = late_r ? '0 : SLOT_W'(didx_r);
    disp_res.len       = (disp_kind == KIND_STORED) ? plen_r : '0;
    disp_res.restarted = restart_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: state_nxt = ST_MOD_S;
      ST_MOD_S: begin
        if (mod_done) state_nxt = forced_r ? ST_MOD_B : ST_DISP;
      end
      ST_MOD_B: begin
        if (mod_done) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (push_ok) begin
          if (forced_r) begin
            state_nxt = ST_F_CHK;
          end else begin
            state_nxt = late_r ? ST_FINISH : ST_STORE;
          end
        end
      end
      ST_F_CHK: begin
        if (walk_end) begin
          state_nxt = late_r ? ST_FINISH : ST_STORE;
        end else if (walk_valid) begin
          state_nxt = ST_F_EMIT;
        end
      end
      ST_F_EMIT: begin
        if (push_ok) state_nxt = ST_F_CHK;
      end
      ST_STORE: state_nxt = ST_MOD_BOT;
      ST_MOD_BOT: begin
        if (mod_done) state_nxt = ST_I_CHK;
      end
      ST_I_CHK: state_nxt = io_stop ? ST_FINISH : ST_I_EMIT;
      ST_I_EMIT: begin
        if (push_ok) state_nxt = bottom_max ? ST_FINISH : ST_I_CHK;
      end
      ST_FINISH: begin
        if (fin_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mod_start = 1'b0;
    mod_div   = bottom_r;
    push      = 1'b0;
    push_res  = disp_res;
    fin       = 1'b0;
    adv       = 1'b0;
    slot_cmd  = '0;
    case (state_r)
      ST_IDLE: slot_cmd.clear_all = in_acc && restart_c;
      ST_CALC: begin
        mod_start = 1'b1;
        mod_div   = s_r;
      end
      ST_MOD_S: mod_start = mod_done && forced_r;
      ST_DISP:  push = push_ok;
      ST_F_CHK: adv = !walk_end && !walk_valid;
      ST_F_EMIT: begin
        push               = push_ok;
        push_res.kind      = KIND_EMIT;
        push_res.seq       = pos_r;
        push_res.slot      = SLOT_W'(idx_r);
        push_res.len       = walk_len;
        push_res.restarted = 1'b0;
        slot_cmd.free_slot = push_ok;
        adv                = push_ok;
      end
      ST_STORE: begin
        mod_start           = 1'b1;
        slot_cmd.store      = (kind_r == KIND_STORED);
        slot_cmd.store_good = ok_r;
      end
      ST_I_EMIT: begin
        push               = push_ok;
        push_res.kind      = KIND_EMIT;
        push_res.seq       = bottom_r;
        push_res.slot      = SLOT_W'(idx_r);
        push_res.len       = walk_len;
        push_res.restarted = 1'b0;
        slot_cmd.free_slot = push_ok;
      end
      ST_FINISH: fin = fin_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= CFG_WINDOW_RESET;
      bottom_r    <= '0;
      top_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        wl_r <= cfg_window_length;
      end
      if (in_acc) begin
        top_r <= top_nxt;
        if (restart_c) bottom_r <= in_seq_number;
      end
      if (state_r == ST_DISP && push_ok && forced_r) begin
        bottom_r <= nbt_r;
      end
      if (state_r == ST_I_EMIT && push_ok && !bottom_max) begin
        bottom_r <= bottom_r + SEQ_W'(1);
      end
      if (push) begin
        pend_v_r <= 1'b1;
      end else if (fin) begin
        pend_v_r <= 1'b0;
      end
      if ((push && pend_v_r) || fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r       <= in_seq_number;
      ok_r      <= in_crc_ok;
      plen_r    <= in_payload_length;
      w_r       <= w_eff;
      restart_r <= restart_c;
    end
    if (state_r == ST_CALC) begin
      d_r   <= top_r - bottom_r;
      ge_r  <= (top_r >= bottom_r);
      nbt_r <= top_r - SEQ_W'(w_r) + SEQ_W'(1);
    end
    // forced_r, k_r and late_r settle while the remainder run is in progress
    if (state_r == ST_MOD_S) begin
      forced_r <= ok_r && ge_r && (d_r >= SEQ_W'(w_r));
      if (d_r >= (SEQ_W'(w_r) + SEQ_W'(w_r) - SEQ_W'(1))) begin
        k_r <= w_r;
      end else begin
        k_r <= d_r[RW-1:0] - w_r + RW'(1);
      end
      late_r <= (s_r < (forced_r ? nbt_r : bottom_r));
      if (mod_done) begin
        didx_r <= IW'(mod_rem);
        pos_r  <= bottom_r;
      end
    end
    if (state_r == ST_MOD_B && mod_done) begin
      idx_r <= IW'(mod_rem);
    end
    if (state_r == ST_DISP && push_ok) begin
      kind_r <= disp_kind;
      cnt_r  <= '0;
    end
    if (adv) begin
      idx_r <= idx_inc;
      pos_r <= pos_r + SEQ_W'(1);
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (state_r == ST_MOD_BOT && mod_done) begin
      idx_r <= IW'(mod_rem);
      cnt_r <= '0;
    end
    if (state_r == ST_I_EMIT && push_ok) begin
      idx_r <= idx_inc;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (push) begin
      pend_r <= push_res;
    end
    if (push && pend_v_r) begin
      out_r      <= pend_r;
      out_last_r <= 1'b0;
    end else if (fin) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_seq        = out_r.seq;
  assign out_slot_index = out_r.slot;
  assign out_length     = out_r.len;
  assign out_restarted  = out_r.restarted;
  assign out_last       = out_last_r;

endmodule

// ===== hw/rtl/srw_mod.sv =====
// Shared remainder unit: 32-bit value modulo window, two bits per cycle.
module srw_mod import srw_pkg::*; #(
  parameter int RW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SEQ_W-1:0] dividend,
  input  logic [RW-1:0]    divisor,
  output logic             done,
  output logic [RW-1:0]    rem
);

  localparam int STEPS = SEQ_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [SEQ_W-1:0] sh_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW:0]      t1;
  logic [RW:0]      r1;
  logic [RW:0]      t2;
  logic [RW:0]      r2;

  always_comb begin
    t1 = {rem_r, sh_r[SEQ_W-1]};
    r1 = (t1 >= {1'b0, divisor}) ? t1 - {1'b0, divisor} : t1;
    t2 = {r1[RW-1:0], sh_r[SEQ_W-2]};
    r2 = (t2 >= {1'b0, divisor}) ? t2 - {1'b0, divisor} : t2;
    rem_nxt = r2[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[SEQ_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/srw_slots.sv =====
// Slot marks (valid, good) in flops and stored lengths in a small memory.
module srw_slots import srw_pkg::*; #(
  parameter int NSLOT = 32,
  parameter int IW    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srw_slot_cmd_t    cmd,
  input  logic [IW-1:0]    walk_idx,
  input  logic [IW-1:0]    store_idx,
  input  logic [LEN_W-1:0] store_len,
  output logic             walk_valid,
  output logic             walk_good,
  output logic             store_good,
  output logic [LEN_W-1:0] walk_len
);

  logic [NSLOT-1:0] valid_r;
  logic [NSLOT-1:0] good_r;
  logic [LEN_W-1:0] len_mem [NSLOT];
  logic [LEN_W-1:0] len_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      good_r  <= '0;
    end else if (cmd.clear_all) begin
      valid_r <= '0;
      good_r  <= '0;
    end else if (cmd.free_slot) begin
      valid_r[walk_idx] <= 1'b0;
      good_r[walk_idx]  <= 1'b0;
    end else if (cmd.store) begin
      valid_r[store_idx] <= 1'b1;
      good_r[store_idx]  <= cmd.store_good;
    end
  end

  // lengths of slots that are not valid are never read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      len_mem[store_idx] <= store_len;
    end
    len_q_r <= len_mem[walk_idx];
  end

  assign walk_valid = valid_r[walk_idx];
  assign walk_good  = good_r[walk_idx];
  assign store_good = good_r[store_idx];
  assign walk_len   = len_q_r;

endmodule

// ===== hw/rtl/srw_checker.sv =====
// Port-level checks for the sequence reorder window, bound to the top level.
`include "sequence_reorder_window_top_macros.svh"

module srw_checker import srw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_kind,
  input logic [SEQ_W-1:0]  out_seq,
  input logic [SLOT_W-1:0] out_slot_index,
  input logic [LEN_W-1:0]  out_length,
  input logic              out_restarted,
  input logic              out_last
);

  `SRW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_seq) && $stable(out_slot_index) && $stable(out_length) && $stable(out_last), "result changed while stalled")

  `SRW_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready right after an input transfer")

  `SRW_ASSERT_IMP(a_idle_no_partial, in_ready, !(out_valid && !out_last), "idle with a non-final result waiting")

  `SRW_ASSERT_IMP(a_zero_len, out_valid && (out_kind == KIND_LATE || out_kind == KIND_DUP), out_length == '0 && (out_kind != KIND_LATE || out_slot_index == '0), "late or duplicate result with length or slot")

endmodule

bind sequence_reorder_window_top srw_checker u_srw_checker (.*);

// ===== tb/sequence_reorder_window_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sequence reorder window: directed table, then random packets.
module sequence_reorder_window_top_test;
  import srw_pkg::*;

  localparam int SLOTS         = 32;
  localparam int RESTART_GAP   = 128;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 40;
  localparam int PLAN_ROWS     = 25;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_PACKETS = 46;

  typedef struct packed {
    srw_kind_t         kind;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              restarted;
    logic              last;
  } packet_result_t;

  // One directed step: either a window write or a packet, optionally with a
  // hand-written disposition that replaces the predicted one.
  typedef struct packed {
    logic              cfg;
    logic [CFG_W-1:0]  window;
    logic [SEQ_W-1:0]  seq;
    logic              crc_ok;
    logic [LEN_W-1:0]  len;
    logic              typed;
    packet_result_t    disp;
  } plan_row_t;

  localparam packet_result_t NO_RESULT = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_window_length = CFG_WINDOW_RESET;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SEQ_W-1:0]  in_seq_number = '0;
  logic              in_crc_ok = 1'b0;
  logic [LEN_W-1:0]  in_payload_length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [SLOT_W-1:0] out_slot_index;
  logic [LEN_W-1:0]  out_length;
  logic              out_restarted;
  logic              out_last;

  // Window state as the block should hold it
  logic [SEQ_W-1:0]  win_bottom;
  logic [SEQ_W-1:0]  win_top;
  logic              slot_held [SLOTS];
  logic              slot_clean [SLOTS];
  logic [LEN_W-1:0]  slot_bytes [SLOTS];
  logic [CFG_W-1:0]  win_setting = CFG_WINDOW_RESET;

  packet_result_t    due_results [$];

  int unsigned burst_left = 0;
  int unsigned packets_sent = 0;
  int unsigned settings_used = 0;
  int unsigned results_seen = 0;
  int unsigned emits_seen = 0;
  int unsigned lates_seen = 0;
  int unsigned dups_seen = 0;
  int unsigned restarts_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  logic [7:0]  ready_phase = '0;
  logic [31:0] ready_bits = '1;

  plan_row_t plan [PLAN_ROWS] = '{
    // in-order start, late repeat, max length, duplicate of a good slot
    '{1'b0, 6'd0, 32'd0, 1'b1, 13'd100, 1'b1,
      '{KIND_STORED, 32'd0, 5'd0, 13'd100, 1'b0, 1'b0}},
    '{1'b0, 6'd0, 32'd0, 1'b1, 13'd5, 1'b1,
      '{KIND_LATE, 32'd0, 5'd0, 13'd0, 1'b0, 1'b1}},
    '{1'b0, 6'd0, 32'd3, 1'b1, 13'd4192, 1'b1,
      '{KIND_STORED, 32'd3, 5'd3, 13'd4192, 1'b0, 1'b1}},
    '{1'b0, 6'd0, 32'd3, 1'b1, 13'd7, 1'b1,
      '{KIND_DUP, 32'd3, 5'd3, 13'd0, 1'b0, 1'b1}},
    // bad checksum stored, then overwritten, then the gap fills
    '{1'b0, 6'd0, 32'd2, 1'b0, 13'd50, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd2, 1'b0, 13'd51, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd1, 1'b1, 13'd9, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd2, 1'b1, 13'd8, 1'b0, NO_RESULT},
    // bad packet raises top without a walk; good one forces a short walk
    '{1'b0, 6'd0, 32'd40, 1'b0, 13'd1, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd41, 1'b1, 13'd2, 1'b0, NO_RESULT},
    // long forced walk, capped at the window, bottom jumps
    '{1'b0, 6'd0, 32'd1000, 1'b1, 13'd300, 1'b0, NO_RESULT},
    // far behind: bad checksum drops, good checksum restarts
    '{1'b0, 6'd0, 32'd500, 1'b0, 13'd10, 1'b1,
      '{KIND_LATE, 32'd500, 5'd0, 13'd0, 1'b0, 1'b1}},
    '{1'b0, 6'd0, 32'd500, 1'b1, 13'd1234, 1'b1,
      '{KIND_STORED, 32'd500, 5'd20, 13'd1234, 1'b1, 1'b0}},
    // single slot: bottom runs into the top of the sequence space and sticks
    '{1'b1, 6'd1, 32'd0, 1'b0, 13'd0, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'hFFFF_FFFF, 1'b1, 13'd4096, 1'b1,
      '{KIND_STORED, 32'hFFFF_FFFF, 5'd0, 13'd4096, 1'b0, 1'b0}},
    '{1'b0, 6'd0, 32'hFFFF_FFFF, 1'b1, 13'd17, 1'b1,
      '{KIND_STORED, 32'hFFFF_FFFF, 5'd0, 13'd17, 1'b0, 1'b0}},
    '{1'b0, 6'd0, 32'hFFFF_FFFF, 1'b0, 13'd3, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'h7FFF_FFFF, 1'b0, 13'd0, 1'b1,
      '{KIND_LATE, 32'h7FFF_FFFF, 5'd0, 13'd0, 1'b0, 1'b1}},
    // zero window behaves as one slot
    '{1'b1, 6'd0, 32'd0, 1'b0, 13'd0, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd5, 1'b1, 13'd4095, 1'b1,
      '{KIND_STORED, 32'd5, 5'd0, 13'd4095, 1'b1, 1'b0}},
    // oversize window behaves as the full slot count
    '{1'b1, 6'd63, 32'd0, 1'b0, 13'd0, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd7, 1'b1, 13'd0, 1'b1,
      '{KIND_STORED, 32'd7, 5'd7, 13'd0, 1'b0, 1'b1}},
    '{1'b0, 6'd0, 32'd6, 1'b1, 13'd2048, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd38, 1'b1, 13'd64, 1'b0, NO_RESULT},
    '{1'b0, 6'd0, 32'd40, 1'b1, 13'd4000, 1'b0, NO_RESULT}
  };

  sequence_reorder_window_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_seq_number     (in_seq_number),
    .in_crc_ok         (in_crc_ok),
    .in_payload_length (in_payload_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_seq           (out_seq),
    .out_slot_index    (out_slot_index),
    .out_length        (out_length),
    .out_restarted     (out_restarted),
    .out_last          (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: fully open a quarter of the time, otherwise a rotating random mask
  always @(posedge clk) begin
    ready_phase <= ready_phase + 8'd1;
    if (ready_phase[5:0] == 6'd0) begin
      ready_bits <= $urandom;
    end else begin
      ready_bits <= {ready_bits[30:0], ready_bits[31]};
    end
    out_ready <= (ready_phase[7:6] == 2'b00) | ready_bits[0] | ready_bits[1];
  end

  function automatic int unsigned active_slots();
    if (win_setting == '0) return 1;
    if (win_setting > CFG_W'(SLOTS)) return SLOTS;
    return 32'(win_setting);
  endfunction

  function automatic packet_result_t free_slot(input logic [SEQ_W-1:0] pos,
                                               input int unsigned idx);
    packet_result_t r;
    r.kind      = KIND_EMIT;
    r.seq       = pos;
    r.slot      = SLOT_W'(idx);
    r.len       = slot_bytes[idx];
    r.restarted = 1'b0;
    r.last      = 1'b0;
    slot_held[idx]  = 1'b0;
    slot_clean[idx] = 1'b0;
    slot_bytes[idx] = '0;
    return r;
  endfunction

  // Works out disposition and releases for one packet and queues them
  task automatic advance_window(input logic [SEQ_W-1:0] s, input logic ok,
                                input logic [LEN_W-1:0] plen, input logic typed,
                                input packet_result_t fixed);
    packet_result_t disp;
    packet_result_t em;
    packet_result_t emits [$];
    int unsigned w;
    int unsigned idx;
    int unsigned i;
    logic [SEQ_W-1:0] steps;
    w = active_slots();
    disp = '0;
    disp.seq = s;
    if (ok && ({32'd0, s} + 64'(RESTART_GAP)) < {32'd0, win_bottom}) begin
      win_bottom = s;
      win_top = s;
      for (i = 0; i < SLOTS; i++) begin
        slot_held[i]  = 1'b0;
        slot_clean[i] = 1'b0;
        slot_bytes[i] = '0;
      end
      disp.restarted = 1'b1;
    end
    if (s > win_top) win_top = s;
    // forced walk: only good packets push old slots out
    if (ok && win_top >= win_bottom && win_top - win_bottom >= w) begin
      steps = win_top - win_bottom - w + 1;
      for (i = 0; i < steps && i < w; i++) begin
        idx = (win_bottom + i) % w;
        if (slot_held[idx]) emits.push_back(free_slot(win_bottom + i, idx));
      end
      win_bottom = win_top - w + 1;
    end
    if (s < win_bottom) begin
      disp.kind = KIND_LATE;
    end else begin
      idx = s % w;
      disp.slot = SLOT_W'(idx);
      if (!slot_clean[idx]) begin
        slot_held[idx]  = 1'b1;
        slot_clean[idx] = ok;
        slot_bytes[idx] = plen;
        disp.kind = KIND_STORED;
        disp.len  = plen;
      end else begin
        disp.kind = KIND_DUP;
      end
      // in-order release; bottom saturates at the top of the number space
      for (i = 0; i <= w && win_bottom <= win_top; i++) begin
        idx = win_bottom % w;
        if (!slot_clean[idx]) break;
        emits.push_back(free_slot(win_bottom, idx));
        if (win_bottom == '1) break;
        win_bottom++;
      end
    end
    disp.last = (emits.size() == 0);
    if (typed) disp = fixed;
    due_results.push_back(disp);
    for (i = 0; i < emits.size(); i++) begin
      em = emits[i];
      em.last = (i == emits.size() - 1);
      due_results.push_back(em);
    end
  endtask

  task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                             input logic [SEQ_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    packet_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      restarts_seen += out_restarted;
      case (out_kind)
        KIND_EMIT: emits_seen++;
        KIND_LATE: lates_seen++;
        KIND_DUP:  dups_seen++;
        default: ;
      endcase
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none actual kind %0d seq %0h",
                   $time, out_kind, out_seq);
        end
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("seq", want.seq, out_seq);
        check_field("slot_index", 32'(want.slot), 32'(out_slot_index));
        check_field("length", 32'(want.len), 32'(out_length));
        check_field("restarted", 32'(want.restarted), 32'(out_restarted));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Sender: bursts of back-to-back packets separated by random gaps
  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic ok,
                             input logic [LEN_W-1:0] plen, input logic typed,
                             input packet_result_t fixed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
      burst_left = $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_seq_number     <= s;
    in_crc_ok         <= ok;
    in_payload_length <= plen;
    do @(posedge clk); while (!in_ready);
    advance_window(s, ok, plen, typed, fixed);
    burst_left--;
    packets_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    cfg_valid         <= 1'b1;
    cfg_window_length <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_setting = value;
    settings_used++;
  endtask

  initial begin
    int unsigned k;
    int unsigned p;
    int unsigned w;
    int unsigned pick;
    logic [SEQ_W-1:0] s;
    logic ok;
    logic [LEN_W-1:0] plen;
    logic [CFG_W-1:0] phase_window [RANDOM_PHASES];
    win_bottom = '0;
    win_top = '0;
    for (k = 0; k < SLOTS; k++) begin
      slot_held[k]  = 1'b0;
      slot_clean[k] = 1'b0;
      slot_bytes[k] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].cfg) begin
        wait_idle();
        write_window(plan[k].window);
      end else begin
        send_packet(plan[k].seq, plan[k].crc_ok, plan[k].len, plan[k].typed, plan[k].disp);
      end
    end

    phase_window[0] = CFG_W'(SLOTS);
    phase_window[1] = CFG_W'(1);
    phase_window[2] = CFG_W'($urandom_range(2, 31));
    phase_window[3] = CFG_W'($urandom_range(2, 8));
    phase_window[4] = CFG_W'($urandom_range(33, 63));
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      write_window(phase_window[p]);
      for (k = 0; k < PHASE_PACKETS; k++) begin
        w = active_slots();
        pick = $urandom_range(0, 99);
        ok = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
          0:       plen = '0;
          1:       plen = LEN_W'(4192);
          default: plen = LEN_W'($urandom_range(0, 4192));
        endcase
        // mostly reordered packets inside the window, then stragglers,
        // repeats, jumps ahead, restarts and plain noise
        if (pick < 65) begin
          s = win_bottom + $urandom_range(0, w + w / 2);
        end else if (pick < 75) begin
          s = win_bottom - $urandom_range(1, 8);
        end else if (pick < 83) begin
          s = win_top - $urandom_range(0, w);
        end else if (pick < 90) begin
          s = win_top + $urandom_range(w, 400);
        end else if (pick < 95) begin
          s = win_bottom - $urandom_range(RESTART_GAP + 1, 5000);
          ok = 1'b1;
        end else begin
          s = $urandom;
          ok = 1'($urandom_range(0, 1));
        end
        send_packet(s, ok, plen, 1'b0, NO_RESULT);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    $display("Covered %0d packets under %0d window settings, %0d results checked",
             packets_sent, settings_used, results_seen);
    $display("(%0d released, %0d late drops, %0d duplicates, %0d window restarts)",
             emits_seen, lates_seen, dups_seen, restarts_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
